// ===== hw/rtl/subcpu_command_port_top_defines.svh =====
// Assertion macros shared by the command port modules.
// Each macro expects a clock named aclk and an active-low reset named aresetn in scope.
`ifndef SUBCPU_COMMAND_PORT_TOP_DEFINES_SVH
`define SUBCPU_COMMAND_PORT_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SCP_ASSERT_HOLD(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SCP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/scp_pkg.sv =====
package scp_pkg;

    // Width of the parameter and read byte counters.
    localparam int CNT_W = 3;

    // Command codes.
    localparam logic [7:0] CMD_TIMER_BASE = 8'hD0;
    localparam logic [7:0] CMD_GET_KEYS   = 8'hE3;
    localparam logic [7:0] CMD_SET_VECT   = 8'hE4;
    localparam logic [7:0] CMD_GET_FLAGS  = 8'hE6;
    localparam logic [7:0] CMD_SET_TV     = 8'hE7;
    localparam logic [7:0] CMD_GET_TV     = 8'hE8;
    localparam logic [7:0] CMD_TAPE_CTRL  = 8'hE9;
    localparam logic [7:0] CMD_TAPE_STAT  = 8'hEA;
    localparam logic [7:0] CMD_TAPE_TYPE  = 8'hEB;
    localparam logic [7:0] CMD_SET_DATE   = 8'hEC;
    localparam logic [7:0] CMD_GET_DATE   = 8'hED;
    localparam logic [7:0] CMD_SET_TIME   = 8'hEE;
    localparam logic [7:0] CMD_GET_TIME   = 8'hEF;

    // Control event kinds.
    localparam logic [1:0] CTRL_NONE = 2'd0;
    localparam logic [1:0] CTRL_TAPE = 2'd1;
    localparam logic [1:0] CTRL_DATE = 2'd2;
    localparam logic [1:0] CTRL_TIME = 2'd3;

    // Result of one beat, as handed from the command core to the output register.
    typedef struct packed {
        logic [7:0]  rd_data;
        logic        rd_from_mem;
        logic        in_ready;
        logic [1:0]  ctrl_kind;
        logic [23:0] ctrl_value;
        logic [7:0]  vector;
        logic [7:0]  tv_ctrl;
    } res_t;

endpackage

// ===== hw/rtl/scp_timer_ram.sv =====
module scp_timer_ram #(
    parameter int DEPTH = 48,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);

    logic [7:0]       mem [DEPTH];
    logic [7:0]       rdata_reg;
    logic [DEPTH-1:0] written_reg;
    logic             rd_written_reg;

    // Single write port; the read data is registered and held between reads.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    // One flag per byte marks it as written since reset; it is read alongside the data.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            written_reg    <= '0;
            rd_written_reg <= 1'b0;
        end else begin
            if (we) begin
                written_reg[waddr] <= 1'b1;
            end
            if (re) begin
                rd_written_reg <= written_reg[raddr];
            end
        end
    end

    // A byte that was never written reads as zero.
    assign rdata = rd_written_reg ? rdata_reg : 8'd0;

endmodule

// ===== hw/rtl/scp_cmd_core.sv =====
`include "subcpu_command_port_top_defines.svh"

module scp_cmd_core #(
    parameter int TIMER_COUNT = 8,
    parameter int TIMER_BYTES = 6,
    localparam int DEPTH = TIMER_COUNT * TIMER_BYTES,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int TW = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               accept,
    input  logic               req_type,
    input  logic [7:0]         wr_data,
    input  logic [23:0]        game_keys_wide,
    input  logic [15:0]        game_keys_flags,
    input  logic [7:0]         tape_ctrl_status,
    input  logic [7:0]         tape_type_status,
    input  logic [23:0]        date_now,
    input  logic [23:0]        time_now,
    output logic               mem_we,
    output logic [AW-1:0]      mem_waddr,
    output logic [7:0]         mem_wdata,
    output logic               mem_re,
    output logic [AW-1:0]      mem_raddr,
    output scp_pkg::res_t      res
);

    typedef enum logic [2:0] {
        RGN_ZERO,
        RGN_TIMER,
        RGN_WORK,
        RGN_VECT,
        RGN_TV
    } region_t;

    localparam int CW = scp_pkg::CNT_W;

    // Architectural state held in flip-flops; the timer bytes live in the RAM.
    logic [7:0]    work0_reg, work1_reg, work2_reg;
    logic [7:0]    work0_next, work1_next, work2_next;
    logic [7:0]    vector_reg, vector_next;
    logic [7:0]    tv_reg, tv_next;
    logic [7:0]    mode_reg, mode_next;
    logic          mode_in_reg, mode_in_next;
    logic [CW-1:0] write_left_reg, write_left_next;
    logic [CW-1:0] read_left_reg, read_left_next;
    region_t       region_reg, region_next;
    logic [TW-1:0] idx_reg, idx_next;
    logic          in_ready_reg, in_ready_next;

    // Command decode of the written byte.
    logic [7:0]    dec_u;
    logic [CW-1:0] dec_cnt;
    logic          dec_in;
    region_t       dec_rgn;
    logic [TW-1:0] dec_idx;

    // Latched input values for the selected input command.
    logic [7:0]    lat_mode;
    logic [7:0]    lat0, lat1, lat2;

    logic          is_write, is_read, cmd_write;
    logic [CW-1:0] wl_dec;
    logic [7:0]    rd_byte;
    logic          rd_mem;
    logic [1:0]    kind;
    logic [23:0]   cval;

    assign is_write  = accept && !req_type;
    assign is_read   = accept && req_type;
    assign cmd_write = is_write && !in_ready_reg && (write_left_reg == '0);
    assign wl_dec    = write_left_reg - CW'(1);

    // Decode a command byte into its byte count, direction and target.
    always_comb begin
        dec_u   = wr_data - scp_pkg::CMD_TIMER_BASE;
        dec_cnt = '0;
        dec_in  = 1'b0;
        dec_rgn = RGN_ZERO;
        dec_idx = '0;
        if (dec_u < 8'h10) begin
            if ({1'b0, dec_u[2:0]} < 4'(TIMER_COUNT)) begin
                dec_cnt = CW'(TIMER_BYTES);
                dec_in  = dec_u[3];
                dec_rgn = RGN_TIMER;
                dec_idx = TW'(dec_u[2:0]);
            end
        end else if (dec_u < 8'h20) begin
            unique case (wr_data) inside
                scp_pkg::CMD_GET_KEYS: begin
                    dec_cnt = CW'(3);
                    dec_in  = 1'b1;
                    dec_rgn = RGN_WORK;
                end
                scp_pkg::CMD_SET_VECT: begin
                    dec_cnt = CW'(1);
                    dec_rgn = RGN_VECT;
                end
                scp_pkg::CMD_GET_FLAGS: begin
                    dec_cnt = CW'(2);
                    dec_in  = 1'b1;
                    dec_rgn = RGN_WORK;
                end
                scp_pkg::CMD_SET_TV: begin
                    dec_cnt = CW'(1);
                    dec_rgn = RGN_TV;
                end
                scp_pkg::CMD_GET_TV: begin
                    dec_cnt = CW'(1);
                    dec_in  = 1'b1;
                    dec_rgn = RGN_TV;
                end
                scp_pkg::CMD_TAPE_CTRL: begin
                    dec_cnt = CW'(1);
                    dec_rgn = RGN_WORK;
                end
                scp_pkg::CMD_TAPE_STAT, scp_pkg::CMD_TAPE_TYPE: begin
                    dec_cnt = CW'(1);
                    dec_in  = 1'b1;
                    dec_rgn = RGN_WORK;
                end
                scp_pkg::CMD_SET_DATE, scp_pkg::CMD_SET_TIME: begin
                    dec_cnt = CW'(3);
                    dec_rgn = RGN_WORK;
                end
                scp_pkg::CMD_GET_DATE, scp_pkg::CMD_GET_TIME: begin
                    dec_cnt = CW'(3);
                    dec_in  = 1'b1;
                    dec_rgn = RGN_WORK;
                end
                default: begin
                    dec_cnt = '0;
                end
            endcase
        end
    end

    // Input capture: a new command latches with its own code, a read with the current one.
    always_comb begin
        lat_mode = cmd_write ? wr_data : mode_reg;
        lat0     = work0_reg;
        lat1     = work1_reg;
        lat2     = work2_reg;
        unique case (lat_mode)
            scp_pkg::CMD_GET_KEYS: begin
                {lat2, lat1, lat0} = game_keys_wide;
            end
            scp_pkg::CMD_GET_FLAGS: begin
                lat1 = game_keys_flags[7:0];
                lat0 = game_keys_flags[15:8];
            end
            scp_pkg::CMD_TAPE_STAT: begin
                lat0 = tape_ctrl_status;
            end
            scp_pkg::CMD_TAPE_TYPE: begin
                lat0 = tape_type_status;
            end
            scp_pkg::CMD_GET_DATE: begin
                {lat2, lat1, lat0} = date_now;
            end
            scp_pkg::CMD_GET_TIME: begin
                {lat2, lat1, lat0} = time_now;
            end
            default: begin
                lat0 = work0_reg;
            end
        endcase
    end

    // Next state, RAM access and the result of the beat.
    always_comb begin
        work0_next      = work0_reg;
        work1_next      = work1_reg;
        work2_next      = work2_reg;
        vector_next     = vector_reg;
        tv_next         = tv_reg;
        mode_next       = mode_reg;
        mode_in_next    = mode_in_reg;
        write_left_next = write_left_reg;
        read_left_next  = read_left_reg;
        region_next     = region_reg;
        idx_next        = idx_reg;
        in_ready_next   = in_ready_reg;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        rd_byte         = 8'd0;
        rd_mem          = 1'b0;
        kind            = scp_pkg::CTRL_NONE;
        cval            = 24'd0;

        if (cmd_write) begin
            // A command byte: set up the target and the byte counters.
            mode_next    = wr_data;
            mode_in_next = dec_in;
            region_next  = dec_rgn;
            idx_next     = dec_idx;
            if (dec_in) begin
                read_left_next = dec_cnt;
                in_ready_next  = 1'b1;
                work0_next     = lat0;
                work1_next     = lat1;
                work2_next     = lat2;
            end else begin
                write_left_next = dec_cnt;
                read_left_next  = '0;
                in_ready_next   = 1'b0;
            end
        end else if (is_write && !in_ready_reg) begin
            // A parameter byte, stored at the next lower offset.
            write_left_next = wl_dec;
            case (region_reg)
                RGN_TIMER: mem_we = 1'b1;
                RGN_WORK: begin
                    if (wl_dec == CW'(0)) work0_next = wr_data;
                    if (wl_dec == CW'(1)) work1_next = wr_data;
                    if (wl_dec == CW'(2)) work2_next = wr_data;
                end
                RGN_VECT: begin
                    if (wl_dec == '0) vector_next = wr_data;
                end
                RGN_TV: begin
                    if (wl_dec == '0) tv_next = wr_data;
                end
                default: mem_we = 1'b0;
            endcase
            if (wl_dec == '0) begin
                case (mode_reg)
                    scp_pkg::CMD_TAPE_CTRL: begin
                        kind = scp_pkg::CTRL_TAPE;
                        cval = {16'd0, work0_next};
                    end
                    scp_pkg::CMD_SET_DATE: begin
                        kind = scp_pkg::CTRL_DATE;
                        cval = {work2_next, work1_next, work0_next};
                    end
                    scp_pkg::CMD_SET_TIME: begin
                        kind = scp_pkg::CTRL_TIME;
                        cval = {work2_next, work1_next, work0_next};
                    end
                    default: kind = scp_pkg::CTRL_NONE;
                endcase
            end
        end else if (is_read) begin
            // A read returns the next byte down, or latches again once drained.
            if (read_left_reg != '0) begin
                read_left_next = read_left_reg - CW'(1);
            end else begin
                work0_next = lat0;
                work1_next = lat1;
                work2_next = lat2;
            end
            in_ready_next = (read_left_next != '0);
            if (mode_in_reg) begin
                case (region_reg)
                    RGN_TIMER: begin
                        mem_re = 1'b1;
                        rd_mem = 1'b1;
                    end
                    RGN_WORK: begin
                        if (read_left_next == CW'(0)) rd_byte = work0_next;
                        if (read_left_next == CW'(1)) rd_byte = work1_next;
                        if (read_left_next == CW'(2)) rd_byte = work2_next;
                    end
                    RGN_VECT: begin
                        if (read_left_next == '0) rd_byte = vector_reg;
                    end
                    RGN_TV: begin
                        if (read_left_next == '0) rd_byte = tv_reg;
                    end
                    default: rd_byte = 8'd0;
                endcase
            end
        end
    end

    // Timer byte addresses: timer index times the timer size plus the byte offset.
    assign mem_waddr = AW'(int'(idx_reg) * TIMER_BYTES + int'(wl_dec));
    assign mem_raddr = AW'(int'(idx_reg) * TIMER_BYTES + int'(read_left_next));
    assign mem_wdata = wr_data;

    // Result handed to the output register.
    always_comb begin
        res.rd_data     = rd_byte;
        res.rd_from_mem = rd_mem;
        res.in_ready    = in_ready_next;
        res.ctrl_kind   = kind;
        res.ctrl_value  = cval;
        res.vector      = vector_next;
        res.tv_ctrl     = tv_next;
    end

    // State registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            work0_reg      <= 8'd0;
            work1_reg      <= 8'd0;
            work2_reg      <= 8'd0;
            vector_reg     <= 8'd0;
            tv_reg         <= 8'd0;
            mode_reg       <= 8'd0;
            mode_in_reg    <= 1'b0;
            write_left_reg <= '0;
            read_left_reg  <= '0;
            region_reg     <= RGN_ZERO;
            idx_reg        <= '0;
            in_ready_reg   <= 1'b0;
        end else begin
            work0_reg      <= work0_next;
            work1_reg      <= work1_next;
            work2_reg      <= work2_next;
            vector_reg     <= vector_next;
            tv_reg         <= tv_next;
            mode_reg       <= mode_next;
            mode_in_reg    <= mode_in_next;
            write_left_reg <= write_left_next;
            read_left_reg  <= read_left_next;
            region_reg     <= region_next;
            idx_reg        <= idx_next;
            in_ready_reg   <= in_ready_next;
        end
    end

    // Pending read data and pending parameter bytes never coexist.
    `SCP_ASSERT_HOLD(a_no_params_when_in, in_ready_reg, write_left_reg == '0, "params pending with read data")
    // Bytes still to read belong to an input command.
    `SCP_ASSERT_HOLD(a_read_left_in_mode, read_left_reg != '0, mode_in_reg, "read bytes in output mode")
    // An output command leaves nothing to read.
    `SCP_ASSERT_NEXT(a_out_cmd_clears, cmd_write && !dec_in, !in_ready_reg && read_left_reg == '0, "output command left read data")

endmodule

// ===== hw/rtl/subcpu_command_port_top.sv =====
// Command port of a keyboard and timer sub-processor. Each beat on the s_ channel is one bus
// access: a write (s_req_type low) carries a command or parameter byte, a read returns the next
// byte of an input command, last byte first. Every accepted beat yields exactly one result beat
// on the m_ channel, carrying the read byte, both status flags, any tape, date or time control
// event and the current vector and TV control registers. A beat is accepted every cycle while the
// output register is free or being emptied, so beats may follow back to back; its result appears
// in the output register on the following cycle. The output register sets this timing, and the
// registered read port of the timer RAM delivers timer bytes in step with it.
// The RAM holds TIMER_COUNT timers of TIMER_BYTES bytes each; a written flag per byte, cleared
// by reset, makes every timer byte read as zero until it is first written.
`include "subcpu_command_port_top_defines.svh"

module subcpu_command_port_top #(
    parameter int TIMER_COUNT = 8,
    parameter int TIMER_BYTES = 6
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_req_type,
    input  logic [7:0]  s_wr_data,
    input  logic [23:0] s_game_keys_wide,
    input  logic [15:0] s_game_keys_flags,
    input  logic [7:0]  s_tape_ctrl_status,
    input  logic [7:0]  s_tape_type_status,
    input  logic [23:0] s_date_now,
    input  logic [23:0] s_time_now,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_rd_data,
    output logic        m_out_ready,
    output logic        m_in_ready,
    output logic [1:0]  m_ctrl_kind,
    output logic [23:0] m_ctrl_value,
    output logic [7:0]  m_vector_out,
    output logic [7:0]  m_tv_ctrl_out
);

    localparam int DEPTH = TIMER_COUNT * TIMER_BYTES;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic          accept;
    logic          mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [7:0]    mem_wdata, mem_rdata;
    scp_pkg::res_t res;
    scp_pkg::res_t res_reg;
    logic          m_valid_reg;

    // A new beat is taken whenever the output register is empty or being emptied.
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    scp_cmd_core #(
        .TIMER_COUNT(TIMER_COUNT),
        .TIMER_BYTES(TIMER_BYTES)
    ) u_core (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .accept           (accept),
        .req_type         (s_req_type),
        .wr_data          (s_wr_data),
        .game_keys_wide   (s_game_keys_wide),
        .game_keys_flags  (s_game_keys_flags),
        .tape_ctrl_status (s_tape_ctrl_status),
        .tape_type_status (s_tape_type_status),
        .date_now         (s_date_now),
        .time_now         (s_time_now),
        .mem_we           (mem_we),
        .mem_waddr        (mem_waddr),
        .mem_wdata        (mem_wdata),
        .mem_re           (mem_re),
        .mem_raddr        (mem_raddr),
        .res              (res)
    );

    scp_timer_ram #(
        .DEPTH(DEPTH)
    ) u_timer_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .we      (mem_we),
        .waddr   (mem_waddr),
        .wdata   (mem_wdata),
        .re      (mem_re),
        .raddr   (mem_raddr),
        .rdata   (mem_rdata)
    );

    // Output register; the RAM read data is held alongside it until the next accepted beat.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (accept) begin
            res_reg <= res;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_rd_data     = res_reg.rd_from_mem ? mem_rdata : res_reg.rd_data;
    assign m_in_ready    = res_reg.in_ready;
    assign m_out_ready   = !res_reg.in_ready;
    assign m_ctrl_kind   = res_reg.ctrl_kind;
    assign m_ctrl_value  = res_reg.ctrl_value;
    assign m_vector_out  = res_reg.vector;
    assign m_tv_ctrl_out = res_reg.tv_ctrl;

    // Every accepted beat is followed by a result beat.
    `SCP_ASSERT_NEXT(a_result_follows, accept, m_valid, "no result after beat")
    // A write beat never returns data.
    `SCP_ASSERT_NEXT(a_write_reads_zero, accept && !s_req_type, m_rd_data == 8'd0, "write data")
    // The two status flags are always complementary.
    `SCP_ASSERT_HOLD(a_flags_exclusive, m_valid, m_out_ready != m_in_ready, "flags agree")

endmodule
